// File: rtl/rgbm_pkg.sv
// shared types, constants and helpers for the rgb color morphology block
package rgbm_pkg;

   localparam int WINDOW_RADIUS_DEF = 1;
   localparam int PIXEL_W           = 24;
   localparam int CHAN_W            = 8;
   localparam int RANK_W            = 10;
   localparam int MODE_W            = 2;
   localparam int CSR_INDEX_W       = 2;

   // operation modes, bit 1 alone selects gradient
   localparam logic [MODE_W-1:0] MODE_ERODE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DILATE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GRADIENT = 2'd2;
   localparam int                MODE_GRADIENT_BIT = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OPERATION_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRUCTURE_MASK = 2'd1;

   localparam logic [MODE_W-1:0] MODE_RESET = MODE_DILATE;

   function automatic int win_taps(input int radius);
      return (2 * radius + 1) * (2 * radius + 1);
   endfunction

   function automatic int csr_data_w(input int taps);
      return (taps > MODE_W) ? taps : MODE_W;
   endfunction

   // one candidate of the rank tree
   typedef struct packed {
      logic               valid;
      logic [RANK_W-1:0]  rank;
      logic [PIXEL_W-1:0] pixel;
   } node_type;

   function automatic logic [CHAN_W-1:0] chan_of(input logic [PIXEL_W-1:0] px, input int idx);
      return px[idx*CHAN_W +: CHAN_W];
   endfunction

   function automatic logic [RANK_W-1:0] rank_of(input logic [PIXEL_W-1:0] px);
      return RANK_W'(px[23:16]) + RANK_W'(px[15:8]) + RANK_W'(px[7:0]);
   endfunction

endpackage

// File: rtl/rgb_color_morphology.sv
// top level: 3x3 color dilation, erosion and gradient on one window per transaction
// pipeline: an accepted window passes through two registers before its result shows on rsp
//   (window register, then result register)
// throughput: one window per clock; the rank trees and gradient subtract are
//   combinational between the two registers, a stall on rsp backs up into req_tready
// reset: synchronous active high, clears both valid flags, operation_mode to dilation
//   and structure_mask to all taps enabled
module rgb_color_morphology #(
   parameter int WINDOW_RADIUS = rgbm_pkg::WINDOW_RADIUS_DEF
) (
   input  logic clock,
   input  logic reset,
   // window in: pixel_up_left, pixel_up, pixel_up_right, pixel_left, pixel_center,
   // pixel_right, pixel_down_left, pixel_down, pixel_down_right (24 bits each)
   input  logic                                                        req_tvalid,
   output logic                                                        req_tready,
   input  logic [rgbm_pkg::win_taps(WINDOW_RADIUS)*rgbm_pkg::PIXEL_W-1:0] req_tdata,
   // result out: out_red, out_green, out_blue (8 bits each)
   output logic                                                        rsp_tvalid,
   input  logic                                                        rsp_tready,
   output logic [3*rgbm_pkg::CHAN_W-1:0]                               rsp_tdata,
   // register writes: index 0 operation_mode, index 1 structure_mask
   input  logic                                                        csr_valid,
   output logic                                                        csr_ready,
   input  logic [rgbm_pkg::CSR_INDEX_W-1:0]                            csr_index,
   input  logic [rgbm_pkg::csr_data_w(rgbm_pkg::win_taps(WINDOW_RADIUS))-1:0] csr_data
);
   import rgbm_pkg::*;

   localparam int TAPS = win_taps(WINDOW_RADIUS);

   logic [MODE_W-1:0] mode;
   logic [TAPS-1:0]   mask;

   // configuration registers
   rgbm_csr #(.TAPS(TAPS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mode      (mode),
      .mask      (mask)
   );

   // window register
   logic                      win_valid_ff, win_valid_in;
   logic [TAPS*PIXEL_W-1:0]   win_data_ff, win_data_in;
   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [3*CHAN_W-1:0]       rsp_data_ff, rsp_data_in;

   logic rsp_open;   // result register can take a value this cycle
   logic win_move;   // window register hands its transaction to the result register
   logic req_take;   // a new window transaction is accepted

   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign win_move   = win_valid_ff && rsp_open;
   assign req_tready = !win_valid_ff || win_move;
   assign req_take   = req_tvalid && req_tready;

   // dilation and erosion trees run side by side
   node_type dil, ero;

   rgbm_rank_select #(.TAPS(TAPS)) u_dilate (
      .pixels   (win_data_ff),
      .enable   (mask),
      .want_max (1'b1),
      .best     (dil)
   );

   rgbm_rank_select #(.TAPS(TAPS)) u_erode (
      .pixels   (win_data_ff),
      .enable   (mask),
      .want_max (1'b0),
      .best     (ero)
   );

   // no enabled tap reads as black
   logic [PIXEL_W-1:0] dil_px, ero_px, sel_px;
   logic [3*CHAN_W-1:0] result;

   assign dil_px = dil.valid ? dil.pixel : '0;
   assign ero_px = ero.valid ? ero.pixel : '0;

   always_comb begin
      logic [CHAN_W-1:0] d_c, e_c;
      d_c    = '0;
      e_c    = '0;
      sel_px = (mode == MODE_DILATE) ? dil_px : ero_px;
      result = '0;
      if (mode[MODE_GRADIENT_BIT]) begin
         // per channel dilation minus erosion, clamped at zero; channel 2 is red
         for (int c = 0; c < 3; c++) begin
            d_c = chan_of(dil_px, 2 - c);
            e_c = chan_of(ero_px, 2 - c);
            result[c*CHAN_W +: CHAN_W] = (d_c > e_c) ? (d_c - e_c) : '0;
         end
      end else begin
         for (int c = 0; c < 3; c++) begin
            result[c*CHAN_W +: CHAN_W] = chan_of(sel_px, 2 - c);
         end
      end
   end

   always_comb begin
      win_valid_in = win_valid_ff;
      win_data_in  = win_data_ff;
      if (req_take) begin
         win_valid_in = 1'b1;
         win_data_in  = req_tdata;
      end else if (win_move) begin
         win_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (win_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      win_data_ff <= win_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a held window with a blocked result register must stall the input side
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      win_valid_ff && !rsp_open |-> !req_tready)
      else $error("window accepted while result register blocked");

   // a transaction leaving the window register shows up on rsp next cycle
   a_move_to_rsp: assert property (@(posedge clock) disable iff (reset)
      win_move |=> rsp_tvalid)
      else $error("window transaction lost before result register");

   // both trees see the same taps, and the maximum never ranks below the minimum
   a_tree_order: assert property (@(posedge clock) disable iff (reset)
      win_valid_ff |-> (dil.valid == ero.valid) && (!dil.valid || dil.rank >= ero.rank))
      else $error("dilation and erosion trees disagree");

   // an empty structuring mask always gives black
   a_empty_mask_black: assert property (@(posedge clock) disable iff (reset)
      win_move && (mask == '0) |=> rsp_tdata == '0)
      else $error("empty mask did not give black");

endmodule

// File: rtl/rgbm_csr.sv
// configuration registers: operation mode and structuring mask
module rgbm_csr #(
   parameter int TAPS = rgbm_pkg::win_taps(rgbm_pkg::WINDOW_RADIUS_DEF)
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rgbm_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [rgbm_pkg::csr_data_w(TAPS)-1:0]    csr_data,
   output logic [rgbm_pkg::MODE_W-1:0]              mode,
   output logic [TAPS-1:0]                          mask
);
   import rgbm_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [TAPS-1:0]   mask_ff, mask_in;
   logic              write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      mode_in = mode_ff;
      mask_in = mask_ff;
      if (write) begin
         if (csr_index == CSR_OPERATION_MODE) begin
            mode_in = csr_data[MODE_W-1:0];
         end
         if (csr_index == CSR_STRUCTURE_MASK) begin
            mask_in = csr_data[TAPS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         mask_ff <= '1;
      end else begin
         mode_ff <= mode_in;
         mask_ff <= mask_in;
      end
   end

   assign mode = mode_ff;
   assign mask = mask_ff;

endmodule

// File: rtl/rgbm_rank_select.sv
// compare tree picking the enabled tap with the largest or smallest rgb sum
module rgbm_rank_select #(
   parameter int TAPS = rgbm_pkg::win_taps(rgbm_pkg::WINDOW_RADIUS_DEF)
) (
   input  logic [TAPS*rgbm_pkg::PIXEL_W-1:0] pixels,
   input  logic [TAPS-1:0]                   enable,
   input  logic                              want_max,
   output rgbm_pkg::node_type                best
);
   import rgbm_pkg::*;

   localparam int LEVELS = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int LEAVES = 2 ** LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;

   node_type tree [NODES];

   // left child is always the earlier tap, so it keeps ties
   function automatic node_type combine(input node_type l, input node_type r, input logic hi);
      logic take_r;
      take_r = r.valid && (!l.valid || (hi ? (r.rank > l.rank) : (r.rank < l.rank)));
      return take_r ? r : l;
   endfunction

   for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < TAPS) begin : g_tap
         assign tree[LEAVES-1+k] = '{
            valid: enable[k],
            rank:  rank_of(pixels[k*PIXEL_W +: PIXEL_W]),
            pixel: pixels[k*PIXEL_W +: PIXEL_W]
         };
      end else begin : g_pad
         assign tree[LEAVES-1+k] = '{valid: 1'b0, rank: '0, pixel: '0};
      end
   end

   for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
      assign tree[i] = combine(tree[2*i+1], tree[2*i+2], want_max);
   end

   assign best = tree[0];

endmodule
